>>> rtl/core/sbec_pkg.sv
`timescale 1ns / 1ps
// sbec_pkg: shared types, constants and helpers of the separable blur block.
// No dependencies; the files that use it refer to it by scoped names.
package sbec_pkg;

   localparam int PIX_W      = 16;
   localparam int COEF_W     = 16;
   localparam int HSUM_W     = 24;
   localparam int CFG_DIM_W  = 11;
   localparam int TAP_CNT_W  = 3;
   localparam int TAPS_TOP   = 5;
   localparam int CMD_COL_W  = 12;
   localparam int CMD_LINE_W = 3;
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;
   localparam int ACC_W      = 44;
   localparam int PROD_W     = 40;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] REG_TAP_COUNT    = 3'd2;
   localparam logic [2:0] REG_COEF_ZERO    = 3'd3;
   localparam logic [2:0] REG_COEF_ONE     = 3'd4;
   localparam logic [2:0] REG_COEF_TWO     = 3'd5;
   localparam logic [2:0] REG_COEF_THREE   = 3'd6;
   localparam logic [2:0] REG_COEF_FOUR    = 3'd7;

   typedef struct packed {
      logic             kind;
      logic [PIX_W-1:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] blurred_value;
      logic             saturated;
      logic             frame_end;
   } rsp_type;

   typedef struct packed {
      logic [CFG_DIM_W-1:0]               frame_width;
      logic [CFG_DIM_W-1:0]               frame_height;
      logic [TAP_CNT_W-1:0]               tap_count;
      logic [TAPS_TOP-1:0][COEF_W-1:0]    coef;
   } cfg_type;

   // one unit of work handed from the front to the back
   typedef struct packed {
      logic [1:0]                         h_count;
      logic [CMD_COL_W-1:0]               h_lo;
      logic [CMD_COL_W-1:0]               h_newest;
      logic [CMD_LINE_W-1:0]              h_line;
      logic [TAPS_TOP-1:0][PIX_W-1:0]     window;
      logic                               do_v;
      logic [CMD_COL_W-1:0]               v_col;
      logic [TAPS_TOP-1:0][CMD_LINE_W-1:0] v_line;
      logic                               last;
   } cmd_type;

   function automatic logic [TAP_CNT_W-1:0] clamp_taps(input logic [TAP_CNT_W-1:0] tc,
                                                       input logic [TAP_CNT_W-1:0] tmax);
      logic [TAP_CNT_W-1:0] r;
      if (tc == '0) begin
         r = TAP_CNT_W'(1);
      end else if (tc > tmax) begin
         r = tmax;
      end else begin
         r = tc;
      end
      return r;
   endfunction

endpackage

>>> rtl/core/sbec_ram.sv
`timescale 1ns / 1ps
// sbec_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbec_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/sbec_queue.sv
`timescale 1ns / 1ps
// sbec_queue: short command queue between front and back.
// Depends on sbec_pkg (cmd_type, queue depth).
module sbec_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sbec_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output sbec_pkg::cmd_type head
);

   localparam int PW = sbec_pkg::QPTR_W;
   localparam int CW = sbec_pkg::QCNT_W;

   sbec_pkg::cmd_type entry_ff [sbec_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(sbec_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(sbec_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full  = (count_ff == CW'(sbec_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

endmodule

>>> rtl/core/sbec_front.sv
`timescale 1ns / 1ps
// sbec_front: accepts transactions, keeps frame counters and the pixel window,
// and issues horizontal/vertical work commands. Depends on sbec_pkg.
module sbec_front #(
   parameter int MAX_TAPS   = 5,
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  sbec_pkg::cfg_type cfg,
   input  logic              req_valid,
   input  sbec_pkg::req_type req_data,
   output logic              req_stall,
   input  logic              q_full,
   output logic              q_push,
   output sbec_pkg::cmd_type q_cmd
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int LW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int PW = sbec_pkg::PIX_W;
   localparam int CC = sbec_pkg::CMD_COL_W;

   logic [XW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [LW-1:0] in_line_ff, in_line_in, out_line_ff, out_line_in;
   logic [PW-1:0] win_ff [MAX_TAPS];
   logic [PW-1:0] win_in [MAX_TAPS];

   logic [31:0]   fw32, fh32;
   logic [WW-1:0] w_eff, wm1, c_next, ox_next;
   logic [RW-1:0] h_eff, hm1, ry, hm1_oy;
   logic [RW:0]   oy_fwd, oy_next;
   logic [2:0]    taps, half, fwd;
   logic [XW-1:0] c, ox;
   logic [XW:0]   ox_fwd;
   logic          accept, abandon, take_pix, row_end, col_last, row_last, c_ge_fwd;
   logic [2:0]    vline [MAX_TAPS];

   assign fw32 = 32'(cfg.frame_width);
   assign fh32 = 32'(cfg.frame_height);
   assign w_eff = (fw32 == 32'd0) ? WW'(1) :
                  (fw32 > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(fw32);
   assign h_eff = (fh32 == 32'd0) ? RW'(1) :
                  (fh32 > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(fh32);
   assign taps = sbec_pkg::clamp_taps(cfg.tap_count, 3'(MAX_TAPS));
   assign half = taps >> 1;
   assign fwd  = taps - 3'd1 - half;
   assign wm1  = w_eff - WW'(1);
   assign hm1  = h_eff - RW'(1);

   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;
   assign abandon   = (out_row_ff >= h_eff);
   assign take_pix  = accept && !abandon && (req_data.kind == sbec_pkg::KIND_PIXEL) &&
                      (in_row_ff < h_eff);

   // input column, clamped to the last column if the width shrank
   assign c        = (WW'(in_col_ff) < w_eff) ? in_col_ff : XW'(wm1);
   assign c_next   = WW'(c) + WW'(1);
   assign row_end  = (c_next >= w_eff);
   assign c_ge_fwd = (c >= XW'(fwd));

   assign ox       = (WW'(out_col_ff) < w_eff) ? out_col_ff : XW'(wm1);
   assign ox_next  = WW'(ox) + WW'(1);
   assign col_last = (ox_next >= w_eff);
   assign ox_fwd   = (XW+1)'(ox) + (XW+1)'(fwd);
   assign oy_fwd   = (RW+1)'(out_row_ff) + (RW+1)'(fwd);
   assign ry       = (oy_fwd > (RW+1)'(hm1)) ? hm1 : RW'(oy_fwd);
   assign oy_next  = (RW+1)'(out_row_ff) + (RW+1)'(1);
   assign row_last = (oy_next >= (RW+1)'(h_eff));
   assign hm1_oy   = hm1 - out_row_ff;

   // line store of each vertical tap: row offset clamped at both frame edges
   always_comb begin
      logic signed [4:0] dk;
      logic signed [4:0] d;
      logic signed [4:0] ls;
      logic [2:0]        mag;
      for (int k = 0; k < MAX_TAPS; k++) begin
         dk  = $signed(5'(k)) - $signed(5'(half));
         d   = dk;
         mag = 3'(-dk);
         if ((dk < 0) && (out_row_ff < RW'(mag))) begin
            d = -$signed({2'b00, out_row_ff[2:0]});
         end else if ((dk > 0) && (hm1_oy < RW'(3'(dk)))) begin
            d = $signed({2'b00, hm1_oy[2:0]});
         end
         ls = $signed(5'(out_line_ff)) + d;
         if (ls < 0) begin
            ls = ls + $signed(5'(MAX_TAPS));
         end else if (ls >= $signed(5'(MAX_TAPS))) begin
            ls = ls - $signed(5'(MAX_TAPS));
         end
         vline[k] = 3'(ls);
      end
   end

   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      in_line_in  = in_line_ff;
      out_line_in = out_line_ff;
      win_in      = win_ff;
      q_cmd       = '0;
      q_push      = 1'b0;
      if (accept && abandon) begin
         // height shrank below the output row: drop the frame
         in_col_in   = '0;
         in_row_in   = '0;
         out_col_in  = '0;
         out_row_in  = '0;
         in_line_in  = '0;
         out_line_in = '0;
      end else if (accept) begin
         if (take_pix) begin
            win_in[0] = req_data.pixel_value;
            for (int j = 1; j < MAX_TAPS; j++) begin
               win_in[j] = win_ff[j-1];
            end
            q_cmd.h_line   = 3'(in_line_ff);
            q_cmd.h_newest = CC'(c);
            if (row_end) begin
               q_cmd.h_count = c_ge_fwd ? 2'(fwd + 3'd1) : 2'(c + XW'(1));
               q_cmd.h_lo    = c_ge_fwd ? CC'(c - XW'(fwd)) : '0;
               in_col_in     = '0;
               in_row_in     = in_row_ff + RW'(1);
               in_line_in    = (in_line_ff == LW'(MAX_TAPS - 1)) ? '0 : in_line_ff + LW'(1);
            end else begin
               q_cmd.h_count = c_ge_fwd ? 2'd1 : 2'd0;
               q_cmd.h_lo    = CC'(c - XW'(fwd));
               in_col_in     = XW'(c_next);
            end
            for (int j = 0; j < MAX_TAPS; j++) begin
               q_cmd.window[j] = win_in[j];
            end
         end
         if ((ry < in_row_in) ||
             ((ry == in_row_in) && (ox_fwd < (XW+1)'(in_col_in)))) begin
            q_cmd.do_v  = 1'b1;
            q_cmd.v_col = CC'(ox);
            for (int k = 0; k < MAX_TAPS; k++) begin
               q_cmd.v_line[k] = vline[k];
            end
            if (col_last) begin
               out_col_in  = '0;
               out_row_in  = RW'(oy_next);
               out_line_in = (out_line_ff == LW'(MAX_TAPS - 1)) ? '0 : out_line_ff + LW'(1);
               if (row_last) begin
                  q_cmd.last  = 1'b1;
                  in_col_in   = '0;
                  in_row_in   = '0;
                  out_col_in  = '0;
                  out_row_in  = '0;
                  in_line_in  = '0;
                  out_line_in = '0;
               end
            end else begin
               out_col_in = XW'(ox_next);
            end
         end
         q_push = q_cmd.do_v || (q_cmd.h_count != 2'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         in_line_ff  <= '0;
         out_line_ff <= '0;
         for (int j = 0; j < MAX_TAPS; j++) begin
            win_ff[j] <= '0;
         end
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         in_line_ff  <= in_line_in;
         out_line_ff <= out_line_in;
         win_ff      <= win_in;
      end
   end

endmodule

>>> rtl/core/sbec_back.sv
`timescale 1ns / 1ps
// sbec_back: executes commands with one shared multiply-accumulate unit,
// owns the line stores and the output register. Depends on sbec_pkg, sbec_ram.
module sbec_back #(
   parameter int MAX_TAPS  = 5,
   parameter int MAX_WIDTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  sbec_pkg::cfg_type cfg,
   input  logic              q_empty,
   input  sbec_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sbec_pkg::rsp_type rsp_data
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int LW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int HW = sbec_pkg::HSUM_W;
   localparam int AW = sbec_pkg::ACC_W;
   localparam int MW = sbec_pkg::PROD_W;
   localparam int PW = sbec_pkg::PIX_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_H_MUL = 3'd1;
   localparam logic [2:0] ST_H_ADD = 3'd2;
   localparam logic [2:0] ST_H_WR  = 3'd3;
   localparam logic [2:0] ST_V_RD  = 3'd4;
   localparam logic [2:0] ST_V_MUL = 3'd5;
   localparam logic [2:0] ST_V_ADD = 3'd6;
   localparam logic [2:0] ST_V_OUT = 3'd7;

   logic [2:0]               state_ff, state_in;
   sbec_pkg::cmd_type        cmd_ff;
   logic [XW-1:0]            hx_ff;
   logic [1:0]               hrem_ff;
   logic [2:0]               k_ff;
   logic signed [AW-1:0]     acc_ff;
   logic signed [MW-1:0]     prod_ff;
   logic                     rsp_valid_ff;
   sbec_pkg::rsp_type        rsp_data_ff;

   logic [2:0]               taps, half;
   logic                     k_last, out_free;
   logic [sbec_pkg::CMD_COL_W-1:0] diff;
   logic signed [4:0]        t;
   logic [2:0]               pix_idx;
   logic [PW-1:0]            pix;
   logic signed [23:0]       mul_a;
   logic signed [15:0]       tap_coef;
   logic signed [MW-1:0]     prod_in;
   logic signed [AW-1:0]     rounded;
   logic [HW-1:0]            rd_data [MAX_TAPS];
   logic [MAX_TAPS-1:0]      line_we;
   logic                     sat_lo, sat_hi;

   assign taps     = sbec_pkg::clamp_taps(cfg.tap_count, 3'(MAX_TAPS));
   assign half     = taps >> 1;
   assign k_last   = (k_ff == taps - 3'd1);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;

   // window slot of tap k for column hx, clamped to the row's first column and to the newest column
   assign diff = cmd_ff.h_newest - sbec_pkg::CMD_COL_W'(hx_ff);
   assign t    = $signed({2'b00, diff[2:0]}) + $signed({2'b00, half}) -
                 $signed({2'b00, k_ff});
   always_comb begin
      if (t < 0) begin
         pix_idx = 3'd0;
      end else if (sbec_pkg::CMD_COL_W'(t) > cmd_ff.h_newest) begin
         pix_idx = cmd_ff.h_newest[2:0];
      end else begin
         pix_idx = 3'(t);
      end
      if (pix_idx > 3'(MAX_TAPS - 1)) begin
         pix_idx = 3'(MAX_TAPS - 1);
      end
   end
   assign pix = cmd_ff.window[pix_idx];

   // shared multiplier
   assign tap_coef = $signed(cfg.coef[k_ff]);
   assign mul_a    = (state_ff == ST_H_MUL) ? $signed({8'd0, pix}) :
                     $signed(rd_data[LW'(cmd_ff.v_line[k_ff])]);
   assign prod_in  = mul_a * tap_coef;

   // round half up and drop 14 fraction bits (floor shift)
   assign rounded = (acc_ff + AW'(8192)) >>> 14;
   assign sat_lo  = (rounded < 0);
   assign sat_hi  = (rounded > $signed(AW'(65535)));

   for (genvar j = 0; j < MAX_TAPS; j++) begin : g_line
      assign line_we[j] = (state_ff == ST_H_WR) && (cmd_ff.h_line == 3'(j));
      sbec_ram #(
         .WIDTH(HW),
         .DEPTH(MAX_WIDTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (line_we[j]),
         .wr_addr (hx_ff),
         .wr_data (rounded[HW-1:0]),
         .rd_addr (cmd_ff.v_col[XW-1:0]),
         .rd_data (rd_data[j])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = (q_head.h_count != 2'd0) ? ST_H_MUL :
                          q_head.do_v ? ST_V_RD : ST_IDLE;
            end
         end
         ST_H_MUL: state_in = ST_H_ADD;
         ST_H_ADD: state_in = k_last ? ST_H_WR : ST_H_MUL;
         ST_H_WR: begin
            if (hrem_ff == 2'd1) begin
               state_in = cmd_ff.do_v ? ST_V_RD : ST_IDLE;
            end else begin
               state_in = ST_H_MUL;
            end
         end
         ST_V_RD:  state_in = ST_V_MUL;
         ST_V_MUL: state_in = ST_V_ADD;
         ST_V_ADD: state_in = k_last ? ST_V_OUT : ST_V_MUL;
         ST_V_OUT: state_in = out_free ? ST_IDLE : ST_V_OUT;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_V_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            cmd_ff  <= q_head;
            hx_ff   <= q_head.h_lo[XW-1:0];
            hrem_ff <= q_head.h_count;
            k_ff    <= '0;
            acc_ff  <= '0;
         end
         ST_H_MUL, ST_V_MUL: prod_ff <= prod_in;
         ST_H_ADD, ST_V_ADD: begin
            acc_ff <= acc_ff + AW'(prod_ff);
            if (!k_last) begin
               k_ff <= k_ff + 3'd1;
            end
         end
         ST_H_WR: begin
            acc_ff  <= '0;
            k_ff    <= '0;
            hx_ff   <= hx_ff + XW'(1);
            hrem_ff <= hrem_ff - 2'd1;
         end
         ST_V_OUT: begin
            if (out_free) begin
               rsp_data_ff.blurred_value <= sat_lo ? '0 : sat_hi ? '1 : rounded[PW-1:0];
               rsp_data_ff.saturated     <= sat_lo || sat_hi;
               rsp_data_ff.frame_end     <= cmd_ff.last;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/separable_blur_edge_clamp.sv
`timescale 1ns / 1ps
// separable_blur_edge_clamp: top level of the streaming separable blur of up to MAX_TAPS taps.
// Depends on sbec_pkg, sbec_front, sbec_queue, sbec_back (and sbec_ram).
//
//   channel  ports                          payload          direction
//   req      req_valid/req_stall/req_data   sbec_pkg::req_type  in
//   rsp      rsp_valid/rsp_stall/rsp_data   sbec_pkg::rsp_type  out
//   csr      psel/penable/pwrite/paddr/...  32-bit registers    in/out
//
// Flow: the front takes a transaction per cycle while the command queue
//   has room. The back runs the multiply and the add of one tap in turn in
//   its shared MAC: each horizontal value (up to three of them at a row's
//   end) is written to a line store after its taps, each output pixel ends
//   with the load of the output register, and every command passes the idle
//   state to be fetched, so the shared MAC sets the pixel rate.
// Reset clears the counters, the pixel window, the queue and the sequencer.
//   Line stores are not cleared; no clearing pass runs after reset.
// A stalled rsp holds the result in the output register; the front and the
//   back go on until the back's next result waits in ST_V_OUT.
module separable_blur_edge_clamp #(
   parameter int MAX_TAPS   = 5,
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  sbec_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output sbec_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sbec_pkg::ADDR_W-1:0]     paddr,
   input  logic [sbec_pkg::DATA_W-1:0]     pwdata,
   output logic [sbec_pkg::DATA_W-1:0]     prdata,
   output logic                            pready
);

   localparam int DW = sbec_pkg::DATA_W;

   sbec_pkg::cfg_type cfg_ff, cfg_in;
   sbec_pkg::cmd_type push_cmd, head_cmd;
   logic              q_push, q_pop, q_full, q_empty, csr_write;
   logic [2:0]        reg_sel;

   assign pready    = 1'b1;
   assign reg_sel   = paddr[4:2];
   assign csr_write = psel && penable && pwrite && pready;

   // register writes; values are masked to the register's width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_sel)
            sbec_pkg::REG_FRAME_WIDTH:  cfg_in.frame_width  = pwdata[10:0];
            sbec_pkg::REG_FRAME_HEIGHT: cfg_in.frame_height = pwdata[10:0];
            sbec_pkg::REG_TAP_COUNT:    cfg_in.tap_count    = pwdata[2:0];
            sbec_pkg::REG_COEF_ZERO:    cfg_in.coef[0]      = pwdata[15:0];
            sbec_pkg::REG_COEF_ONE:     cfg_in.coef[1]      = pwdata[15:0];
            sbec_pkg::REG_COEF_TWO:     cfg_in.coef[2]      = pwdata[15:0];
            sbec_pkg::REG_COEF_THREE:   cfg_in.coef[3]      = pwdata[15:0];
            sbec_pkg::REG_COEF_FOUR:    cfg_in.coef[4]      = pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= 11'd128;
         cfg_ff.frame_height <= 11'd128;
         cfg_ff.tap_count    <= 3'd5;
         cfg_ff.coef[0]      <= 16'd1024;
         cfg_ff.coef[1]      <= 16'd4096;
         cfg_ff.coef[2]      <= 16'd6144;
         cfg_ff.coef[3]      <= 16'd4096;
         cfg_ff.coef[4]      <= 16'd1024;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (reg_sel)
         sbec_pkg::REG_FRAME_WIDTH:  prdata = DW'(cfg_ff.frame_width);
         sbec_pkg::REG_FRAME_HEIGHT: prdata = DW'(cfg_ff.frame_height);
         sbec_pkg::REG_TAP_COUNT:    prdata = DW'(cfg_ff.tap_count);
         sbec_pkg::REG_COEF_ZERO:    prdata = DW'(cfg_ff.coef[0]);
         sbec_pkg::REG_COEF_ONE:     prdata = DW'(cfg_ff.coef[1]);
         sbec_pkg::REG_COEF_TWO:     prdata = DW'(cfg_ff.coef[2]);
         sbec_pkg::REG_COEF_THREE:   prdata = DW'(cfg_ff.coef[3]);
         sbec_pkg::REG_COEF_FOUR:    prdata = DW'(cfg_ff.coef[4]);
         default:                    prdata = '0;
      endcase
   end

   // front: counters, window, decides which transaction yields an output
   sbec_front #(
      .MAX_TAPS   (MAX_TAPS),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   sbec_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (head_cmd)
   );

   // back: horizontal values into the line stores, then the vertical sum
   sbec_back #(
      .MAX_TAPS  (MAX_TAPS),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_head    (head_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/core/sbec_checker.sv
`timescale 1ns / 1ps
// sbec_checker: port-level checks of the blur top level, bound to it below.
// Depends on sbec_pkg and separable_blur_edge_clamp.
module sbec_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input sbec_pkg::req_type               req_data,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input sbec_pkg::rsp_type               rsp_data,
   input logic                            psel,
   input logic                            penable,
   input logic                            pwrite,
   input logic [sbec_pkg::ADDR_W-1:0]     paddr,
   input logic [sbec_pkg::DATA_W-1:0]     pwdata,
   input logic [sbec_pkg::DATA_W-1:0]     prdata,
   input logic                            pready
);

   // a stalled result transaction stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp payload changed while stalled");

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // width register reads back what was written
   a_width_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && (paddr[4:2] == sbec_pkg::REG_FRAME_WIDTH)
      |=> (paddr[4:2] != sbec_pkg::REG_FRAME_WIDTH) ||
          (prdata[10:0] == $past(pwdata[10:0])))
      else $error("frame width readback mismatch");

endmodule

bind separable_blur_edge_clamp sbec_checker u_checker (.*);
